### rtl/core/modular_arithmetic_unit_core_defines.svh
// Assertion helpers for the core control file
`ifndef MODULAR_ARITHMETIC_UNIT_CORE_DEFINES_SVH
`define MODULAR_ARITHMETIC_UNIT_CORE_DEFINES_SVH
// Implication checked on every rising clock edge outside reset
`define MAU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication checked outside reset
`define MAU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

### rtl/core/mau_pkg.sv
package mau_pkg;
  localparam int Width = 32;
  localparam int ExpBits = 64;
  localparam int ExpCntW = $clog2(ExpBits + 1);
  localparam int BitCntW = $clog2(Width + 1);

  localparam logic [2:0] ModeAdd = 3'd0;
  localparam logic [2:0] ModeSub = 3'd1;
  localparam logic [2:0] ModeMul = 3'd2;
  localparam logic [2:0] ModeDiv = 3'd3;
  localparam logic [2:0] ModeInv = 3'd4;
  localparam logic [2:0] ModeExp = 3'd5;

  typedef struct packed {
    logic [2:0]         mode;
    logic [Width-1:0]   operand_a;
    logic [Width-1:0]   operand_b;
    logic [ExpBits-1:0] exponent;
  } in_req_t;

  typedef struct packed {
    logic [Width-1:0] result;
    logic             status;
  } out_req_t;

  // datapath operations
  typedef enum logic [3:0] {
    OpNone, OpLoad, OpRedA, OpRedB, OpAddSub, OpMulStart, OpMulStep,
    OpInvInit, OpDivStart, OpDivStep, OpInvUpd, OpExpInit, OpExpShift,
    OpSetMulAccSq, OpSetMulSqSq, OpSetMulAB
  } op_t;

  typedef struct packed {
    op_t  op;
    logic wb_acc;   // write multiplier result to acc
    logic wb_sq;    // write multiplier result to sq
    logic wb_res;   // write multiplier result to result
    logic wb_t;     // alone: copy inverse or power to result; with AB multiply: use inverse as b
  } cmd_t;

  typedef struct packed {
    logic busy;      // multi-step unit still running
    logic r1_zero;
    logic r0_one;
    logic e_bit;
    logic exp_done;
  } sts_t;
endpackage

### rtl/core/modular_arithmetic_unit_core.sv
// Every request first reduces both operands by the modulus (two serial reductions); add,
// subtract and spare modes then finish, multiply runs one serial multiply, inverse and
// divide run Euclid rounds (divide then multiplies by the inverse), and exponentiation steps through each exponent bit.
// Throughput: one request at a time, the next accepted once the result is registered;
// a result waiting at the output does not hold the input.
// Reset (rst_n low, synchronous) clears control and sets the modulus to 1.
module modular_arithmetic_unit_core (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  mau_pkg::in_req_t    in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output mau_pkg::out_req_t   out_data,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [1:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  logic [mau_pkg::Width-1:0] modulus_r, res_w;
  mau_pkg::in_req_t  req_r;
  mau_pkg::out_req_t out_r;
  mau_pkg::cmd_t cmd;
  mau_pkg::sts_t sts;
  logic st_bit;
  logic out_load;

  // single register at address zero; writes elsewhere are dropped
  assign pready = 1'b1;
  assign prdata = (paddr == 2'd0) ? modulus_r : '0;
  always_ff @(posedge clk) begin
    if (!rst_n) modulus_r <= 32'd1;
    else if (psel && penable && pwrite && paddr == 2'd0) modulus_r <= pwdata;
  end

  // hold the accepted request for the datapath load, and the finished result
  // until the receiver takes it; a zero result accompanies a missing inverse
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_r <= '0;
      out_r <= '0;
    end else begin
      if (in_valid && !in_stall) req_r <= in_data;
      if (out_load) begin
        out_r.result <= st_bit ? '0 : res_w;
        out_r.status <= st_bit;
      end
    end
  end

  mau_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_mode(in_data.mode), .out_stall, .sts, .cmd,
    .in_stall, .out_valid, .out_load, .status(st_bit)
  );

  mau_datapath u_dp (
    .clk, .rst_n, .cmd, .req(req_r), .modulus(modulus_r), .sts, .res_o(res_w)
  );

  assign out_data = out_r;
endmodule

### rtl/core/mau_datapath.sv
module mau_datapath (
  input  logic                  clk,
  input  logic                  rst_n,
  input  mau_pkg::cmd_t         cmd,
  input  mau_pkg::in_req_t      req,
  input  logic [mau_pkg::Width-1:0] modulus,
  output mau_pkg::sts_t         sts,
  output logic [mau_pkg::Width-1:0] res_o
);
  localparam int W = mau_pkg::Width;
  localparam int BITW = mau_pkg::BitCntW;

  logic [W-1:0] m_r, a_r, b_r;
  logic [mau_pkg::ExpBits-1:0] e_r;
  logic [mau_pkg::ExpCntW-1:0] ecnt_r;
  logic [2:0] mode_r;
  // shared serial unit: remainder/divide and double-and-add multiply
  logic [W-1:0] num_r, den_r, quo_r, rem_r;
  logic [W-1:0] mx_r, my_r, macc_r;
  logic [BITW-1:0] cnt_r;
  logic div_run_r, mul_run_r;
  logic [1:0] red_sel_r;  // 1 a, 2 b, 3 euclid
  logic [W-1:0] r0_r, r1_r, t0_r, t1_r, acc_r, sq_r, res_r;

  function automatic logic [W-1:0] addm(input logic [W-1:0] x, input logic [W-1:0] y,
                                       input logic [W-1:0] m);
    logic [W:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) s = s - {1'b0, m};
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] subm(input logic [W-1:0] x, input logic [W-1:0] y,
                                       input logic [W-1:0] m);
    return (x >= y) ? x - y : x + (m - y);
  endfunction

  logic [W:0] rsh;
  logic [W-1:0] mdbl;
  assign rsh  = {rem_r, num_r[W-1]};
  assign mdbl = addm(macc_r, macc_r, m_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_run_r <= 1'b0;
      mul_run_r <= 1'b0;
    end else begin
      case (cmd.op)
        mau_pkg::OpLoad: begin
          m_r <= (modulus == '0) ? W'(1) : modulus;
          a_r <= req.operand_a; b_r <= req.operand_b;
          e_r <= req.exponent; mode_r <= req.mode;
          res_r <= '0;
        end
        mau_pkg::OpRedA: begin
          num_r <= a_r; den_r <= m_r; rem_r <= '0; cnt_r <= BITW'(W);
          div_run_r <= 1'b1; red_sel_r <= 2'd1;
        end
        mau_pkg::OpRedB: begin
          num_r <= b_r; den_r <= m_r; rem_r <= '0; cnt_r <= BITW'(W);
          div_run_r <= 1'b1; red_sel_r <= 2'd2;
        end
        mau_pkg::OpDivStart: begin
          num_r <= r0_r; den_r <= r1_r; rem_r <= '0; cnt_r <= BITW'(W);
          div_run_r <= 1'b1; red_sel_r <= 2'd3;
        end
        mau_pkg::OpDivStep: if (div_run_r) begin
          num_r <= {num_r[W-2:0], 1'b0};
          if (rsh >= {1'b0, den_r}) begin
            rem_r <= W'(rsh - {1'b0, den_r});
            quo_r <= {quo_r[W-2:0], 1'b1};
          end else begin
            rem_r <= rsh[W-1:0];
            quo_r <= {quo_r[W-2:0], 1'b0};
          end
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == BITW'(1)) begin
            div_run_r <= 1'b0;
            if (red_sel_r == 2'd1) a_r <= (rsh >= {1'b0, den_r}) ?
                W'(rsh - {1'b0, den_r}) : rsh[W-1:0];
            if (red_sel_r == 2'd2) b_r <= (rsh >= {1'b0, den_r}) ?
                W'(rsh - {1'b0, den_r}) : rsh[W-1:0];
          end
        end
        mau_pkg::OpAddSub:
          res_r <= (mode_r == mau_pkg::ModeAdd) ? addm(a_r, b_r, m_r) : subm(a_r, b_r, m_r);
        mau_pkg::OpSetMulAB: begin
          mx_r <= a_r; my_r <= cmd.wb_t ? t0_r : b_r; macc_r <= '0; cnt_r <= BITW'(W);
          mul_run_r <= 1'b1;
        end
        mau_pkg::OpSetMulAccSq: begin
          mx_r <= acc_r; my_r <= sq_r; macc_r <= '0; cnt_r <= BITW'(W); mul_run_r <= 1'b1;
        end
        mau_pkg::OpSetMulSqSq: begin
          mx_r <= sq_r; my_r <= sq_r; macc_r <= '0; cnt_r <= BITW'(W); mul_run_r <= 1'b1;
        end
        mau_pkg::OpMulStart: begin
          // q mod m times t1: q <= r0 <= m, so one subtract reduces it
          mx_r <= t1_r; my_r <= (quo_r >= m_r) ? quo_r - m_r : quo_r;
          macc_r <= '0; cnt_r <= BITW'(W); mul_run_r <= 1'b1;
        end
        mau_pkg::OpMulStep: if (mul_run_r) begin
          macc_r <= my_r[W-1] ? addm(mdbl, mx_r, m_r) : mdbl;
          my_r <= {my_r[W-2:0], 1'b0};
          cnt_r <= cnt_r - 1'b1;
          if (cnt_r == BITW'(1)) mul_run_r <= 1'b0;
        end
        mau_pkg::OpInvInit: begin
          r0_r <= m_r; r1_r <= (mode_r == mau_pkg::ModeDiv) ? b_r : a_r;
          t0_r <= '0; t1_r <= (m_r == W'(1)) ? '0 : W'(1);
        end
        mau_pkg::OpInvUpd: begin
          r0_r <= r1_r; r1_r <= rem_r;
          t0_r <= t1_r; t1_r <= subm(t0_r, macc_r, m_r);
        end
        mau_pkg::OpExpInit: begin
          acc_r <= (m_r == W'(1)) ? '0 : W'(1); sq_r <= a_r;
          ecnt_r <= mau_pkg::ExpCntW'(mau_pkg::ExpBits);
        end
        mau_pkg::OpExpShift: begin
          e_r <= e_r >> 1; ecnt_r <= ecnt_r - 1'b1;
        end
        default: ;
      endcase
      if (cmd.wb_acc) acc_r <= macc_r;
      if (cmd.wb_sq)  sq_r  <= macc_r;
      if (cmd.wb_res) res_r <= macc_r;
      if (cmd.op == mau_pkg::OpNone && cmd.wb_t)
        res_r <= (mode_r == mau_pkg::ModeExp) ? acc_r : t0_r;
    end
  end

  assign sts.busy     = div_run_r | mul_run_r;
  assign sts.r1_zero  = (r1_r == '0);
  assign sts.r0_one   = (r0_r == W'(1)) || (m_r == W'(1));
  assign sts.e_bit    = e_r[0];
  assign sts.exp_done = (ecnt_r == '0);
  assign res_o = res_r;
endmodule

### rtl/core/mau_ctrl.sv
`include "modular_arithmetic_unit_core_defines.svh"
module mau_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  input  logic [2:0]       in_mode,
  input  logic             out_stall,
  input  mau_pkg::sts_t    sts,
  output mau_pkg::cmd_t    cmd,
  output logic             in_stall,
  output logic             out_valid,
  output logic             out_load,
  output logic             status
);
  typedef enum logic [4:0] {
    S_IDLE, S_RA, S_RAW, S_RBW, S_DISP, S_MULW, S_INV, S_DIVW, S_QM, S_QMW,
    S_IUPD, S_INVEND, S_DMULW, S_EINIT, S_EBIT, S_EAW, S_ESQ, S_ESQW, S_DONE, S_OUT
  } state_t;
  state_t st_r;
  logic [2:0] mode_r;
  logic busy_q;

  assign in_stall = (st_r != S_IDLE);
  // load the output register once the previous result has gone or is taken in the same cycle
  assign out_load = (st_r == S_OUT) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; out_valid <= 1'b0; status <= 1'b0; cmd <= '0;
      mode_r <= '0; busy_q <= 1'b0;
    end else begin
      cmd <= '0;
      busy_q <= 1'b0;
      if (out_load) out_valid <= 1'b1;
      else if (out_valid && !out_stall) out_valid <= 1'b0;
      case (st_r)
        S_IDLE: if (in_valid && !in_stall) begin
          mode_r <= in_mode; status <= 1'b0;
          cmd.op <= mau_pkg::OpLoad; st_r <= S_RA;
        end
        S_RA:  begin cmd.op <= mau_pkg::OpRedA; busy_q <= 1'b1; st_r <= S_RAW; end
        S_RAW: if (!busy_q && !sts.busy) begin
          cmd.op <= mau_pkg::OpRedB; busy_q <= 1'b1; st_r <= S_RBW;
        end else cmd.op <= mau_pkg::OpDivStep;
        S_RBW: if (!busy_q && !sts.busy) st_r <= S_DISP;
               else cmd.op <= mau_pkg::OpDivStep;
        S_DISP: case (mode_r)
          mau_pkg::ModeAdd, mau_pkg::ModeSub: begin
            cmd.op <= mau_pkg::OpAddSub; st_r <= S_DONE;
          end
          mau_pkg::ModeMul: begin
            cmd.op <= mau_pkg::OpSetMulAB; busy_q <= 1'b1; st_r <= S_MULW;
          end
          mau_pkg::ModeDiv, mau_pkg::ModeInv: begin
            cmd.op <= mau_pkg::OpInvInit; st_r <= S_QM;
          end
          mau_pkg::ModeExp: begin cmd.op <= mau_pkg::OpExpInit; st_r <= S_EINIT; end
          default: st_r <= S_DONE;
        endcase
        S_MULW: if (!busy_q && !sts.busy) begin
          cmd.wb_res <= 1'b1; st_r <= S_DONE;
        end else cmd.op <= mau_pkg::OpMulStep;
        // wait in this state while the Euclid registers update
        S_QM: st_r <= S_INV;
        S_INV: if (sts.r1_zero) st_r <= S_INVEND;
               else begin
                 cmd.op <= mau_pkg::OpDivStart; busy_q <= 1'b1; st_r <= S_DIVW;
               end
        S_DIVW: if (!busy_q && !sts.busy) begin
          cmd.op <= mau_pkg::OpMulStart; busy_q <= 1'b1; st_r <= S_QMW;
        end else cmd.op <= mau_pkg::OpDivStep;
        S_QMW: if (!busy_q && !sts.busy) begin
          cmd.op <= mau_pkg::OpInvUpd; st_r <= S_QM;
        end else cmd.op <= mau_pkg::OpMulStep;
        S_INVEND:
          if (!sts.r0_one) begin status <= 1'b1; st_r <= S_DONE; end
          else if (mode_r == mau_pkg::ModeInv) begin cmd.wb_t <= 1'b1; st_r <= S_DONE; end
          else begin
            // a times inverse: the AB multiply takes the inverse in place of b
            cmd.op <= mau_pkg::OpSetMulAB; cmd.wb_t <= 1'b1; busy_q <= 1'b1;
            st_r <= S_DMULW;
          end
        S_DMULW: if (!busy_q && !sts.busy) begin
          cmd.wb_res <= 1'b1; st_r <= S_DONE;
        end else cmd.op <= mau_pkg::OpMulStep;
        S_EBIT:
          if (sts.exp_done) begin cmd.wb_t <= 1'b1; st_r <= S_DONE; end
          else if (sts.e_bit) begin
            cmd.op <= mau_pkg::OpSetMulAccSq; busy_q <= 1'b1; st_r <= S_EAW;
          end else begin
            cmd.op <= mau_pkg::OpSetMulSqSq; busy_q <= 1'b1; st_r <= S_ESQW;
          end
        S_EAW: if (!busy_q && !sts.busy) begin
          cmd.wb_acc <= 1'b1; st_r <= S_ESQ;
        end else cmd.op <= mau_pkg::OpMulStep;
        S_ESQ: begin
          cmd.op <= mau_pkg::OpSetMulSqSq; busy_q <= 1'b1; st_r <= S_ESQW;
        end
        S_ESQW: if (!busy_q && !sts.busy) begin
          cmd.wb_sq <= 1'b1; cmd.op <= mau_pkg::OpExpShift; st_r <= S_EINIT;
        end else cmd.op <= mau_pkg::OpMulStep;
        S_EINIT: st_r <= S_EBIT;
        S_DONE: st_r <= S_OUT;
        S_OUT: if (out_load) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end

  `MAU_ASSERT_NXT(a_accept_start, in_valid && !in_stall, st_r == S_RA, "accept not started")
  `MAU_ASSERT_NXT(a_load_valid, out_load, out_valid, "result not shown")
  `MAU_ASSERT_IMP(a_status_mode, out_valid && status,
                  mode_r == mau_pkg::ModeDiv || mode_r == mau_pkg::ModeInv, "bad status")
endmodule
